// ===== rtl/tmhq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_pkg
// Shared types, codes and sizes of the timer min-heap queue.
// ----------------------------------------------------------------------------
package tmhq_pkg;

  localparam int HEAP_DEPTH_DEF = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int NW             = $clog2(MAX_RESULTS + 1);
  localparam int ENTRY_W        = 64;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_STARTED   = 3'd0,
    ST_CANCELLED = 3'd1,
    ST_FIRED     = 3'd2,
    ST_ERROR     = 3'd3,
    ST_NONE      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_NOT_FOUND = 2'd2
  } err_t;

endpackage

// ===== rtl/tmhq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_if
// Valid/ready channels for the command and result items.
// ----------------------------------------------------------------------------
interface tmhq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] delay_ticks;
  logic [31:0] cancel_id;
  modport source (output valid, command, delay_ticks, cancel_id, input ready);
  modport sink   (input valid, command, delay_ticks, cancel_id, output ready);
endinterface

interface tmhq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  error_kind;
  logic [31:0] result_ident;
  logic        last;
  modport source (output valid, status, error_kind, result_ident, last, input ready);
  modport sink   (input valid, status, error_kind, result_ident, last, output ready);
endinterface

// ===== rtl/tmhq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmhq_ram #(
  parameter int W = 64,
  parameter int D = 32
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                  wdata,
  input  logic                          re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                  rdata
);
  logic [W-1:0] mem [D];

  // write port, then registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/timer_min_heap_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_min_heap_queue_top
// Timer queue kept as a binary min-heap of (expiry, id) in one RAM.
// ----------------------------------------------------------------------------
// Commands are taken one at a time; the heap lives in a single RAM with one
// write and one registered read port, so every heap step goes through that RAM.
// Start appends the new entry and climbs it toward the root. Cancel scans ids
// in heap order, then moves the last entry into the hole and sifts it up or
// down. Tick pops the root while it is due and fewer than MAX_RESULTS have
// fired, each time pulling the last entry to the root and sifting it down.
// Clear and heap-full answers go out directly. A stalled result register
// holds the sequencer. A new command is accepted while the previous answer
// still waits in the output register.
module timer_min_heap_queue_top #(
  parameter int HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  tmhq_in_if.sink       in_ch,
  tmhq_out_if.source    out_ch
);
  import tmhq_pkg::*;

  localparam int IW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, S_SU, S_SU_CMP, S_SD_L, S_SD_R, S_SD_C,
    S_C_RD, S_C_CMP, S_LOAD, S_T_RD, S_T_CHK, S_T_FIN
  } state_t;

  typedef enum logic [1:0] {M_START, M_CANCEL, M_TICK} mode_t;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [31:0]         next_id_r, next_id_nxt;
  logic [31:0]         now_r, now_nxt;
  logic [ENTRY_W-1:0]  cur_r, cur_nxt;
  logic [ENTRY_W-1:0]  lft_r, lft_nxt;
  logic [IW-1:0]       pos_r, pos_nxt;
  logic                moved_r, moved_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [31:0]         cid_r, cid_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic                have_r, have_nxt;
  logic [31:0]         pend_r, pend_nxt;
  logic [2:0]          res_st_r, res_st_nxt;
  logic [1:0]          res_err_r, res_err_nxt;
  logic [31:0]         res_id_r, res_id_nxt;

  logic                out_valid_r;
  logic [2:0]          out_st_r;
  logic [1:0]          out_err_r;
  logic [31:0]         out_id_r;
  logic                out_last_r;

  logic                emit;
  logic [2:0]          emit_st;
  logic [1:0]          emit_err;
  logic [31:0]         emit_id;
  logic                emit_last;
  logic                can_emit;

  logic                we, re;
  logic [IW-1:0]       waddr, raddr;
  logic [ENTRY_W-1:0]  wdata, rdata;

  logic [CW-1:0]       cnt_m1;
  logic [IW-1:0]       parent;
  logic [IW+1:0]       lidx, ridx;
  logic                r_ok;
  logic [ENTRY_W-1:0]  best;
  logic [IW-1:0]       best_idx;
  logic                best_cur;

  tmhq_ram #(.W(ENTRY_W), .D(HEAP_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .re, .raddr, .rdata
  );

  assign can_emit     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cnt_m1       = count_r - 1'b1;
  assign parent       = IW'((pos_r - 1'b1) >> 1);
  assign lidx         = {1'b0, pos_r, 1'b1};
  assign ridx         = lidx + 1'b1;
  assign r_ok         = ridx < (IW+2)'(count_r);

  // pick the smallest of the moving entry and its children
  always_comb begin
    best     = cur_r;
    best_idx = pos_r;
    best_cur = 1'b1;
    if (lft_r < best) begin
      best     = lft_r;
      best_idx = lidx[IW-1:0];
      best_cur = 1'b0;
    end
    if (r_ok && (rdata < best)) begin
      best     = rdata;
      best_idx = ridx[IW-1:0];
      best_cur = 1'b0;
    end
  end

  // command sequencer
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    now_nxt     = now_r;
    cur_nxt     = cur_r;
    lft_nxt     = lft_r;
    pos_nxt     = pos_r;
    moved_nxt   = moved_r;
    idx_nxt     = idx_r;
    cid_nxt     = cid_r;
    n_nxt       = n_r;
    have_nxt    = have_r;
    pend_nxt    = pend_r;
    res_st_nxt  = res_st_r;
    res_err_nxt = res_err_r;
    res_id_nxt  = res_id_r;
    emit        = 1'b0;
    emit_st     = ST_NONE;
    emit_err    = ERR_NONE;
    emit_id     = '0;
    emit_last   = 1'b1;
    we          = 1'b0;
    waddr       = pos_r;
    wdata       = cur_r;
    re          = 1'b0;
    raddr       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_err_nxt = ERR_NONE;
          res_id_nxt  = '0;
          case (cmd_t'(in_ch.command))
            CMD_START: begin
              if (count_r == CW'(HEAP_DEPTH)) begin
                res_st_nxt  = ST_ERROR;
                res_err_nxt = ERR_FULL;
                state_nxt   = S_RESP;
              end else begin
                next_id_nxt = next_id_r + 1'b1;
                cur_nxt     = {now_r + in_ch.delay_ticks, next_id_r + 1'b1};
                pos_nxt     = count_r[IW-1:0];
                count_nxt   = count_r + 1'b1;
                moved_nxt   = 1'b0;
                mode_nxt    = M_START;
                state_nxt   = S_SU;
              end
            end
            CMD_CANCEL: begin
              cid_nxt   = in_ch.cancel_id;
              idx_nxt   = '0;
              mode_nxt  = M_CANCEL;
              state_nxt = S_C_RD;
            end
            CMD_TICK: begin
              now_nxt   = now_r + 1'b1;
              n_nxt     = '0;
              have_nxt  = 1'b0;
              mode_nxt  = M_TICK;
              state_nxt = S_T_RD;
            end
            default: begin
              count_nxt  = '0;
              res_st_nxt = ST_NONE;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end

      S_RESP: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_st   = res_st_r;
          emit_err  = res_err_r;
          emit_id   = res_id_r;
          state_nxt = S_IDLE;
        end
      end

      // climb toward the root, moving parents down into the hole
      S_SU: begin
        if (pos_r == '0) begin
          we = 1'b1;
          if (mode_r == M_CANCEL && !moved_r) begin
            we        = 1'b0;
            lft_nxt   = '1;
            state_nxt = S_SD_L;
          end else if (mode_r == M_START) begin
            res_st_nxt = ST_STARTED;
            res_id_nxt = cur_r[31:0];
            state_nxt  = S_RESP;
          end else begin
            res_st_nxt = ST_CANCELLED;
            res_id_nxt = cid_r;
            state_nxt  = S_RESP;
          end
        end else begin
          re        = 1'b1;
          raddr     = parent;
          state_nxt = S_SU_CMP;
        end
      end

      S_SU_CMP: begin
        if (cur_r < rdata) begin
          we        = 1'b1;
          wdata     = rdata;
          pos_nxt   = parent;
          moved_nxt = 1'b1;
          state_nxt = S_SU;
        end else if (mode_r == M_CANCEL && !moved_r) begin
          lft_nxt   = '1;
          state_nxt = S_SD_L;
        end else begin
          we = 1'b1;
          if (mode_r == M_START) begin
            res_st_nxt = ST_STARTED;
            res_id_nxt = cur_r[31:0];
          end else begin
            res_st_nxt = ST_CANCELLED;
            res_id_nxt = cid_r;
          end
          state_nxt = S_RESP;
        end
      end

      // descend, moving the smaller child up into the hole
      S_SD_L: begin
        if (lidx >= (IW+2)'(count_r)) begin
          we = 1'b1;
          if (mode_r == M_TICK) begin
            state_nxt = S_T_RD;
          end else begin
            res_st_nxt = ST_CANCELLED;
            res_id_nxt = cid_r;
            state_nxt  = S_RESP;
          end
        end else begin
          re        = 1'b1;
          raddr     = lidx[IW-1:0];
          state_nxt = S_SD_R;
        end
      end

      S_SD_R: begin
        lft_nxt = rdata;
        if (r_ok) begin
          re    = 1'b1;
          raddr = ridx[IW-1:0];
        end
        state_nxt = S_SD_C;
      end

      S_SD_C: begin
        we = 1'b1;
        if (best_cur) begin
          if (mode_r == M_TICK) begin
            state_nxt = S_T_RD;
          end else begin
            res_st_nxt = ST_CANCELLED;
            res_id_nxt = cid_r;
            state_nxt  = S_RESP;
          end
        end else begin
          wdata     = best;
          pos_nxt   = best_idx;
          state_nxt = S_SD_L;
        end
      end

      // scan ids in heap order
      S_C_RD: begin
        if (idx_r == count_r) begin
          res_st_nxt  = ST_ERROR;
          res_err_nxt = ERR_NOT_FOUND;
          res_id_nxt  = cid_r;
          state_nxt   = S_RESP;
        end else begin
          re        = 1'b1;
          raddr     = idx_r[IW-1:0];
          state_nxt = S_C_CMP;
        end
      end

      S_C_CMP: begin
        if (rdata[31:0] == cid_r) begin
          count_nxt = cnt_m1;
          pos_nxt   = idx_r[IW-1:0];
          if (idx_r == cnt_m1) begin
            res_st_nxt = ST_CANCELLED;
            res_id_nxt = cid_r;
            state_nxt  = S_RESP;
          end else begin
            re        = 1'b1;
            raddr     = cnt_m1[IW-1:0];
            state_nxt = S_LOAD;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_C_RD;
        end
      end

      // take the last entry as the one to place
      S_LOAD: begin
        cur_nxt   = rdata;
        moved_nxt = 1'b0;
        lft_nxt   = '1;
        if (mode_r == M_TICK) begin
          pos_nxt   = '0;
          state_nxt = S_SD_L;
        end else begin
          state_nxt = S_SU;
        end
      end

      S_T_RD: begin
        if (count_r == '0 || n_r == NW'(MAX_RESULTS)) begin
          state_nxt = S_T_FIN;
        end else begin
          re        = 1'b1;
          raddr     = '0;
          state_nxt = S_T_CHK;
        end
      end

      // pop the root if due; the previous fired id goes out as not last
      S_T_CHK: begin
        if (rdata[63:32] <= now_r) begin
          if (!have_r || can_emit) begin
            if (have_r) begin
              emit      = 1'b1;
              emit_st   = ST_FIRED;
              emit_id   = pend_r;
              emit_last = 1'b0;
            end
            have_nxt  = 1'b1;
            pend_nxt  = rdata[31:0];
            n_nxt     = n_r + 1'b1;
            count_nxt = cnt_m1;
            if (cnt_m1 != '0) begin
              re        = 1'b1;
              raddr     = cnt_m1[IW-1:0];
              state_nxt = S_LOAD;
            end else begin
              state_nxt = S_T_FIN;
            end
          end
        end else begin
          state_nxt = S_T_FIN;
        end
      end

      S_T_FIN: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_st   = have_r ? ST_FIRED : ST_NONE;
          emit_id   = have_r ? pend_r : 32'd0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_START;
      count_r     <= '0;
      next_id_r   <= '0;
      now_r       <= '0;
      n_r         <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      count_r   <= count_nxt;
      next_id_r <= next_id_nxt;
      now_r     <= now_nxt;
      n_r       <= n_nxt;
      have_r    <= have_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    lft_r     <= lft_nxt;
    pos_r     <= pos_nxt;
    moved_r   <= moved_nxt;
    idx_r     <= idx_nxt;
    cid_r     <= cid_nxt;
    pend_r    <= pend_nxt;
    res_st_r  <= res_st_nxt;
    res_err_r <= res_err_nxt;
    res_id_r  <= res_id_nxt;
    if (emit) begin
      out_st_r   <= emit_st;
      out_err_r  <= emit_err;
      out_id_r   <= emit_id;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.error_kind   = out_err_r;
  assign out_ch.result_ident = out_id_r;
  assign out_ch.last         = out_last_r;
endmodule

// ===== rtl/tmhq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmhq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module tmhq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [1:0]  error_kind,
  input logic [31:0] result_ident,
  input logic        last
);
  import tmhq_pkg::*;

  logic [1:0] open_r;

  // count items whose final result is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_r + 2'((in_valid && in_ready) ? 1 : 0)
                       - 2'((out_valid && out_ready && last) ? 1 : 0);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_ident) && $stable(status))
    else $error("result dropped or changed while stalled");

  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> open_r != 2'd0)
    else $error("result with no item outstanding");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((error_kind == ERR_NONE) == (status != ST_ERROR)))
    else $error("error kind does not match status");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_FIRED) |-> last)
    else $error("single answer without last");
endmodule

bind timer_min_heap_queue_top tmhq_checker u_tmhq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .error_kind   (out_ch.error_kind),
  .result_ident (out_ch.result_ident),
  .last         (out_ch.last)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timer min-heap queue.
// ----------------------------------------------------------------------------
// A queue of commands is built up front: a directed part first, then random
// traffic. A clocked driver presents the commands on the input channel. At
// each accepted command, an in-bench heap model computes the results it
// expects. A clocked monitor compares every result item, field by field,
// with the oldest expected result. Both channels idle at random in phases,
// and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import tmhq_pkg::*;

  localparam int DEPTH      = HEAP_DEPTH_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_LEN   = 400;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] delay;
    logic [31:0] cid;
  } command_t;

  typedef struct {
    status_t     status;
    err_t        err;
    logic [31:0] id;
    logic        last;
  } answer_t;

  logic clk;
  logic rst_n;

  tmhq_in_if  in_ch ();
  tmhq_out_if out_ch ();

  timer_min_heap_queue_top #(.HEAP_DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  command_t    pending_cmds[$];
  answer_t     expected_answers[$];
  int          errors;
  int          n_accepted;
  int          stall_cycles;
  int          hold_left;
  bit          hold_done;

  // Heap model state
  logic [31:0] tm_expiry[DEPTH];
  logic [31:0] tm_ident[DEPTH];
  int          tm_count;
  logic [31:0] tm_next_id;
  logic [31:0] tm_now;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset, once at the start
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_START;
    in_ch.delay_ticks  = '0;
    in_ch.cancel_id    = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Heap order: expiry first, then id
  function automatic bit earlier(int a, int b);
    if (tm_expiry[a] != tm_expiry[b]) return tm_expiry[a] < tm_expiry[b];
    return tm_ident[a] < tm_ident[b];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [31:0] e;
    logic [31:0] d;
    e = tm_expiry[a];
    d = tm_ident[a];
    tm_expiry[a] = tm_expiry[b];
    tm_ident[a]  = tm_ident[b];
    tm_expiry[b] = e;
    tm_ident[b]  = d;
  endfunction

  function automatic void climb(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!earlier(i, p)) break;
      swap_entries(i, p);
      i = p;
    end
  endfunction

  function automatic void sink_down(int i);
    int l;
    int r;
    int m;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < tm_count && earlier(l, m)) m = l;
      if (r < tm_count && earlier(r, m)) m = r;
      if (m == i) break;
      swap_entries(i, m);
      i = m;
    end
  endfunction

  function automatic void expect_answer(status_t s, err_t e, logic [31:0] id, logic last);
    answer_t a;
    a.status = s;
    a.err    = e;
    a.id     = id;
    a.last   = last;
    expected_answers.insert(expected_answers.size(), a);
  endfunction

  // Advance the heap model by one command and queue its answers
  function automatic void apply_command(command_t c);
    int i;
    int n;
    case (c.cmd)
      CMD_START: begin
        if (tm_count >= DEPTH) begin
          expect_answer(ST_ERROR, ERR_FULL, '0, 1'b1);
        end else begin
          tm_next_id = tm_next_id + 1;
          tm_expiry[tm_count] = tm_now + c.delay;
          tm_ident[tm_count]  = tm_next_id;
          tm_count++;
          climb(tm_count - 1);
          expect_answer(ST_STARTED, ERR_NONE, tm_next_id, 1'b1);
        end
      end
      CMD_CANCEL: begin
        for (i = 0; i < tm_count; i++)
          if (tm_ident[i] == c.cid) break;
        if (i >= tm_count) begin
          expect_answer(ST_ERROR, ERR_NOT_FOUND, c.cid, 1'b1);
        end else begin
          tm_count--;
          if (i < tm_count) begin
            tm_expiry[i] = tm_expiry[tm_count];
            tm_ident[i]  = tm_ident[tm_count];
            climb(i);
            sink_down(i);
          end
          expect_answer(ST_CANCELLED, ERR_NONE, c.cid, 1'b1);
        end
      end
      CMD_TICK: begin
        n = 0;
        tm_now = tm_now + 1;
        while (n < MAX_RESULTS && tm_count > 0 && tm_expiry[0] <= tm_now) begin
          expect_answer(ST_FIRED, ERR_NONE, tm_ident[0], 1'b0);
          n++;
          tm_count--;
          if (tm_count > 0) begin
            tm_expiry[0] = tm_expiry[tm_count];
            tm_ident[0]  = tm_ident[tm_count];
            sink_down(0);
          end
        end
        if (n == 0) expect_answer(ST_NONE, ERR_NONE, '0, 1'b1);
        else expected_answers[$].last = 1'b1;
      end
      default: begin
        tm_count = 0;
        expect_answer(ST_NONE, ERR_NONE, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void add_cmd(cmd_t k, logic [31:0] d, logic [31:0] id);
    command_t c;
    c.cmd   = k;
    c.delay = d;
    c.cid   = id;
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Idle percentage of each side in the current phase
  function automatic int sender_idle_pct();
    case ((n_accepted / 80) % 4)
      1: return 74;
      3: return 29;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((n_accepted / 80) % 4)
      2: return 74;
      3: return 29;
      default: return 0;
    endcase
  endfunction

  // Build the command list
  initial begin
    int          started;
    int          r;
    logic [31:0] d;
    tm_count   = 0;
    tm_next_id = '0;
    tm_now     = '0;
    // Directed: extremes, every command, not-found, empty tick and clear
    add_cmd(CMD_START, 32'd0, 32'd0);
    add_cmd(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cmd(CMD_TICK, 32'hFFFF_FFFF, 32'd0);
    add_cmd(CMD_CANCEL, 32'd0, 32'd0);
    add_cmd(CMD_CANCEL, 32'd0, 32'hFFFF_FFFF);
    add_cmd(CMD_CANCEL, 32'd0, 32'd2);
    add_cmd(CMD_CLEAR, 32'd0, 32'd0);
    add_cmd(CMD_TICK, 32'd0, 32'd0);
    // Fill the heap, overflow it, then fire a big run at once
    for (int k = 0; k < DEPTH; k++) add_cmd(CMD_START, $urandom_range(1, 2), '0);
    add_cmd(CMD_START, 32'd5, '0);
    add_cmd(CMD_TICK, '0, '0);
    add_cmd(CMD_TICK, '0, '0);
    add_cmd(CMD_TICK, '0, '0);
    started = DEPTH + 2;
    // Random: mostly short timers, ticks and cancels of recent ids
    for (int k = 0; k < 276; k++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
        add_cmd(CMD_START, d, $urandom);
        started++;
      end else if (r < 62) begin
        if ($urandom_range(0, 4) != 0)
          add_cmd(CMD_CANCEL, $urandom, started - $urandom_range(0, 8));
        else
          add_cmd(CMD_CANCEL, $urandom, $urandom);
      end else if (r < 96) begin
        add_cmd(CMD_TICK, $urandom, $urandom);
      end else begin
        add_cmd(CMD_CLEAR, $urandom, $urandom);
      end
    end
  end

  // Driver: present commands, predict at each accepted item
  always @(posedge clk) begin
    command_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        c.cmd   = cmd_t'(in_ch.command);
        c.delay = in_ch.delay_ticks;
        c.cid   = in_ch.cancel_id;
        apply_command(c);
        n_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          c = pending_cmds.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.command     <= c.cmd;
          in_ch.delay_ticks <= c.delay;
          in_ch.cancel_id   <= c.cid;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check result items, drive ready with stalls and one long hold
  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result: status %0d err %0d id %0h last %0b", $time,
                   out_ch.status, out_ch.error_kind, out_ch.result_ident, out_ch.last);
          errors++;
        end else begin
          a = expected_answers.pop_front();
          if (out_ch.status !== a.status || out_ch.error_kind !== a.err ||
              out_ch.result_ident !== a.id || out_ch.last !== a.last) begin
            $display("%0t: mismatch: expected %0d %0d %0h %0b, got %0d %0d %0h %0b",
                     $time, a.status, a.err, a.id, a.last, out_ch.status,
                     out_ch.error_kind, out_ch.result_ident, out_ch.last);
            errors++;
          end
        end
      end
      if (!hold_done && n_accepted >= 60) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct());
      end
    end
  end

  // Watchdog: end the run after too long without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // End of run
  initial begin
    errors     = 0;
    n_accepted = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    @(posedge rst_n);
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_ch.valid || expected_answers.size() != 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
